@@ rtl/core/lag_pkg.sv @@
// Shared constants, types and codes for the life-like automaton grid.
`default_nettype none

package lag_pkg;

  // Grid geometry and derived widths.
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int COL_W       = $clog2(GRID_WIDTH);
  localparam int ROW_W       = $clog2(GRID_HEIGHT);

  // Rule masks and neighbor counts.
  localparam int MASK_W = 9;
  localparam int CNT_W  = 4;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MASK    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVAL_MASK = 8'd1;
  localparam logic [MASK_W-1:0]    BIRTH_RESET       = 9'd8;
  localparam logic [MASK_W-1:0]    SURVIVAL_RESET    = 9'd12;

  // One row of cells as stored in the grid memory.
  typedef logic [GRID_WIDTH-1:0] row_t;

  // Request operation codes.
  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_SET     = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_TOGGLE  = 3'd3,
    KIND_ADVANCE = 3'd4
  } kind_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CELL_WR  = 6'b000010,
    ST_ADV_SCAN = 6'b000100,
    ST_ADV_LAST = 6'b001000,
    ST_ADV_DONE = 6'b010000,
    ST_SPARE    = 6'b100000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/lag_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/life_like_automaton_grid.sv @@
// Life-like automaton grid: a row-wide memory with read-modify-write access and a row scanner.
// A cell request reads its row through the registered read port of the row memory, then
// writes the row back and registers the result; req_stall holds new requests until it is done.
// An advance request reads one row and writes one row per cycle through a three-row window,
// then writes the last row in ST_ADV_LAST and gives the result in ST_ADV_DONE.
// Reset: both masks take their reset values and a valid bit per row marks every row
// dead at once, so no clearing pass runs and a request can be accepted right after reset.
`default_nettype none

module life_like_automaton_grid
  import lag_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Request channel.
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [2:0]           kind,
  input  wire logic [5:0]           cell_x,
  input  wire logic [5:0]           cell_y,
  // Response channel.
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic                      cell_alive,
  // Configuration write channel.
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MASK_W-1:0]    cfg_data
);

  // Next row of cells from the three old rows around it.
  function automatic row_t next_row(
    input row_t              up,
    input row_t              mid,
    input row_t              dn,
    input logic [MASK_W-1:0] bmask,
    input logic [MASK_W-1:0] smask
  );
    row_t             ul;
    row_t             ur;
    row_t             ml;
    row_t             mr;
    row_t             dl;
    row_t             dr;
    row_t             res;
    logic [CNT_W-1:0] n;
    ul = up << 1;
    ur = up >> 1;
    ml = mid << 1;
    mr = mid >> 1;
    dl = dn << 1;
    dr = dn >> 1;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      n = CNT_W'(ul[c]) + CNT_W'(up[c]) + CNT_W'(ur[c]) + CNT_W'(ml[c]) +
          CNT_W'(mr[c]) + CNT_W'(dl[c]) + CNT_W'(dn[c]) + CNT_W'(dr[c]);
      res[c] = mid[c] ? smask[n] : bmask[n];
    end
    return res;
  endfunction

  state_t            state;
  state_t            state_next;
  logic [MASK_W-1:0] birth_mask;
  logic [MASK_W-1:0] survival_mask;
  logic [GRID_HEIGHT-1:0] row_valid;
  logic              rd_ok;
  logic [2:0]        op_kind;
  logic [COL_W-1:0]  op_col;
  logic [ROW_W-1:0]  op_row;
  logic              op_inside;
  logic [ROW_W-1:0]  scan_row;
  row_t              win_up;
  row_t              win_mid;

  logic              req_accept;
  logic              out_free;
  logic              rd_en;
  logic [ROW_W-1:0]  rd_addr;
  row_t              rd_data;
  row_t              rd_row;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr;
  row_t              wr_data;
  logic              cell_old;
  logic              cell_new;
  row_t              cell_row;
  row_t              adv_row;
  logic              emit;
  logic              emit_bit;

  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign cfg_ready  = 1'b1;

  // Rows never written since reset read as dead.
  assign rd_row = rd_ok ? rd_data : '0;

  lag_ram #(
    .WIDTH(GRID_WIDTH),
    .DEPTH(GRID_HEIGHT)
  ) u_grid (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Single-cell update on the row just read.
  always_comb begin
    cell_old = rd_row[op_col];
    unique case (op_kind)
      KIND_SET:    cell_new = 1'b1;
      KIND_CLEAR:  cell_new = 1'b0;
      KIND_TOGGLE: cell_new = ~cell_old;
      default:     cell_new = cell_old;
    endcase
    cell_row         = rd_row;
    cell_row[op_col] = cell_new;
  end

  // The generation step for the center row of the window.
  assign adv_row = next_row(win_up, win_mid, (state == ST_ADV_LAST) ? '0 : rd_row,
                            birth_mask, survival_mask);

  // Sequencer: memory port control and next state.
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = scan_row - ROW_W'(1);
    wr_data    = adv_row;
    emit       = 1'b0;
    emit_bit   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          rd_en = 1'b1;
          if (kind == KIND_ADVANCE) begin
            rd_addr    = '0;
            state_next = ST_ADV_SCAN;
          end else begin
            rd_addr    = ROW_W'(cell_y);
            state_next = ST_CELL_WR;
          end
        end
      end
      ST_CELL_WR: begin
        if (out_free) begin
          wr_en      = op_inside;
          wr_addr    = op_row;
          wr_data    = cell_row;
          emit       = 1'b1;
          emit_bit   = op_inside && cell_new;
          state_next = ST_IDLE;
        end
      end
      ST_ADV_SCAN: begin
        wr_en = (scan_row != '0);
        if (32'(scan_row) == GRID_HEIGHT - 1) begin
          state_next = ST_ADV_LAST;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_row + ROW_W'(1);
        end
      end
      ST_ADV_LAST: begin
        wr_en      = 1'b1;
        wr_addr    = scan_row;
        state_next = ST_ADV_DONE;
      end
      ST_ADV_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, row valid bits and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      rd_ok     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rd_en) begin
        rd_ok <= row_valid[rd_addr];
      end
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      cell_alive <= emit_bit;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask    <= BIRTH_RESET;
      survival_mask <= SURVIVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_BIRTH_MASK) begin
        birth_mask <= cfg_data;
      end else if (cfg_index == CFG_SURVIVAL_MASK) begin
        survival_mask <= cfg_data;
      end
    end
  end

  // Captured request fields for a cell operation.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      op_kind   <= kind;
      op_col    <= COL_W'(cell_x);
      op_row    <= ROW_W'(cell_y);
      op_inside <= (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
    end
  end

  // Row scan counter and the window of old rows above and at the row being written.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      scan_row <= '0;
      win_up   <= '0;
    end else if (state == ST_ADV_SCAN) begin
      win_up  <= (scan_row == '0) ? '0 : win_mid;
      win_mid <= rd_row;
      if (32'(scan_row) != GRID_HEIGHT - 1) begin
        scan_row <= scan_row + ROW_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
